@@ rtl/tmc_pkg.sv @@
// tmc_pkg: shared types and constants for the trackball motion conditioner
// no dependencies; used by every module under rtl

package tmc_pkg;

    // field widths
    localparam int MOTION_W = 8;
    localparam int TIME_W   = 32;
    localparam int HOLD_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // stream widths
    localparam int S_TDATA_W = 64;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = 1;

    // drag-scroll divisor: default and largest supported value width
    localparam int WHEEL_DIV_DEF = 8;
    localparam int DIV_W         = 7;

    // configuration reset values
    localparam logic [7:0]  SMALL_THR_RST    = 8'd2;
    localparam logic [15:0] DECEL_HOLD_RST   = 16'd200;
    localparam logic [15:0] DOUBLE_GAP_RST   = 16'd25;
    localparam logic [15:0] STREAK_GAP_RST   = 16'd10;
    localparam logic [7:0]  STREAK_THR_RST   = 8'd60;
    localparam logic [7:0]  STREAK_MAX       = 8'd255;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SMALL_THR  = 3'd0,
        CFG_DECEL_HOLD = 3'd1,
        CFG_DOUBLE_GAP = 3'd2,
        CFG_STREAK_GAP = 3'd3,
        CFG_STREAK_THR = 3'd4
    } t_cfg_idx;

    // configuration bundle
    typedef struct packed {
        logic [7:0]  small_thr;
        logic [15:0] decel_hold;
        logic [15:0] double_gap;
        logic [15:0] streak_gap;
        logic [7:0]  streak_thr;
    } t_cfg;

endpackage

@@ rtl/tmc_cfg_regs.sv @@
// tmc_cfg_regs: configuration register file with plain write port
// depends on tmc_pkg

module tmc_cfg_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [tmc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [tmc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output tmc_pkg::t_cfg                      o_cfg
);

    tmc_pkg::t_cfg r_cfg;

    // register writes, unused indexes dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.small_thr  <= tmc_pkg::SMALL_THR_RST;
            r_cfg.decel_hold <= tmc_pkg::DECEL_HOLD_RST;
            r_cfg.double_gap <= tmc_pkg::DOUBLE_GAP_RST;
            r_cfg.streak_gap <= tmc_pkg::STREAK_GAP_RST;
            r_cfg.streak_thr <= tmc_pkg::STREAK_THR_RST;
        end else if (i_cfg_we) begin
            case (tmc_pkg::t_cfg_idx'(i_cfg_idx))
                tmc_pkg::CFG_SMALL_THR:  r_cfg.small_thr  <= i_cfg_data[7:0];
                tmc_pkg::CFG_DECEL_HOLD: r_cfg.decel_hold <= i_cfg_data;
                tmc_pkg::CFG_DOUBLE_GAP: r_cfg.double_gap <= i_cfg_data;
                tmc_pkg::CFG_STREAK_GAP: r_cfg.streak_gap <= i_cfg_data;
                tmc_pkg::CFG_STREAK_THR: r_cfg.streak_thr <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/tmc_scroll_axis.sv @@
// tmc_scroll_axis: one drag-scroll axis, remainder register and constant divide
// depends on tmc_pkg; divide by reciprocal multiply, exact for 8-bit magnitudes

module tmc_scroll_axis #(
    parameter int WHEEL_DIV = tmc_pkg::WHEEL_DIV_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic signed [tmc_pkg::MOTION_W-1:0] i_d,
    output logic signed [tmc_pkg::MOTION_W-1:0] o_wheel
);

    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int PROD_W      = tmc_pkg::MOTION_W + RECIP_W;
    localparam int BACK_W      = tmc_pkg::MOTION_W + tmc_pkg::DIV_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((2 ** RECIP_SHIFT) + WHEEL_DIV - 1) / WHEEL_DIV);
    localparam logic [tmc_pkg::DIV_W-1:0] DIV_C = tmc_pkg::DIV_W'(WHEEL_DIV);

    // remainder magnitude always stays below the divisor
    logic signed [tmc_pkg::MOTION_W-1:0] r_rem;
    logic signed [tmc_pkg::MOTION_W-1:0] n_rem;

    logic signed [tmc_pkg::MOTION_W:0]   w_sum;
    logic                                w_neg;
    logic [tmc_pkg::MOTION_W-1:0]        w_mag;
    logic [PROD_W-1:0]                   w_prod;
    logic [tmc_pkg::MOTION_W-1:0]        w_qm;
    logic [BACK_W-1:0]                   w_back;
    logic [tmc_pkg::DIV_W-1:0]           w_rm;
    logic [tmc_pkg::MOTION_W-1:0]        w_wheel;

    // remainder plus motion, split into sign and magnitude
    always_comb begin
        w_sum  = {r_rem[tmc_pkg::MOTION_W-1], r_rem} + {i_d[tmc_pkg::MOTION_W-1], i_d};
        w_neg  = w_sum[tmc_pkg::MOTION_W];
        w_mag  = w_neg ? tmc_pkg::MOTION_W'(-w_sum) : w_sum[tmc_pkg::MOTION_W-1:0];
    end

    // quotient toward zero and remainder
    always_comb begin
        w_prod = PROD_W'(w_mag) * PROD_W'(RECIP);
        w_qm   = w_prod[RECIP_SHIFT +: tmc_pkg::MOTION_W];
        w_back = BACK_W'(w_qm) * BACK_W'(DIV_C);
        w_rm   = tmc_pkg::DIV_W'(BACK_W'(w_mag) - w_back);
        n_rem  = w_neg ? tmc_pkg::MOTION_W'(-{1'b0, w_rm}) : tmc_pkg::MOTION_W'({1'b0, w_rm});
    end

    // negated quotient, saturated to the signed 8-bit range
    always_comb begin
        if (w_neg) begin
            w_wheel = (w_qm > 8'd127) ? 8'd127 : w_qm;
        end else begin
            w_wheel = (w_qm > 8'd128) ? 8'h80 : tmc_pkg::MOTION_W'(-w_qm);
        end
    end

    assign o_wheel = w_wheel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= '0;
        end else if (i_en) begin
            r_rem <= n_rem;
        end
    end

endmodule

@@ rtl/tmc_motion_core.sv @@
// tmc_motion_core: small-move deceleration, jitter filter and wake flag
// depends on tmc_pkg; holds the deceleration and streak state

module tmc_motion_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  tmc_pkg::t_cfg                       i_cfg,
    input  logic signed [tmc_pkg::MOTION_W-1:0] i_x,
    input  logic signed [tmc_pkg::MOTION_W-1:0] i_y,
    input  logic [tmc_pkg::TIME_W-1:0]          i_now,
    input  logic                                i_jit_on,
    input  logic                                i_layer,
    output logic signed [tmc_pkg::MOTION_W-1:0] o_x,
    output logic signed [tmc_pkg::MOTION_W-1:0] o_y,
    output logic                                o_sig
);

    localparam int MAG_W = tmc_pkg::MOTION_W + 1;

    logic                              r_small_mode;
    logic [tmc_pkg::HOLD_W-1:0]        r_small_start;
    logic [tmc_pkg::TIME_W-1:0]        r_last_double;
    logic [tmc_pkg::TIME_W-1:0]        r_last_single;
    logic [7:0]                        r_streak;

    logic                              n_small_mode;
    logic [tmc_pkg::HOLD_W-1:0]        n_small_start;
    logic [7:0]                        n_streak;

    logic [tmc_pkg::MOTION_W-1:0]      w_absx0, w_absy0, w_absx1, w_absy1;
    logic [MAG_W-1:0]                  w_mag0, w_mag1, w_magj;
    logic                              w_nonzero, w_small;
    logic [tmc_pkg::HOLD_W-1:0]        w_elapsed;
    logic                              w_slow;
    logic signed [tmc_pkg::MOTION_W-1:0] w_x1, w_y1;
    logic                              w_active, w_is2, w_treat1, w_small1;
    logic [tmc_pkg::TIME_W-1:0]        w_dgap, w_sgap;
    logic [7:0]                        w_streak_eff;
    logic                              w_zero;

    function automatic logic [tmc_pkg::MOTION_W-1:0] f_abs(
        input logic signed [tmc_pkg::MOTION_W-1:0] v
    );
        return v[tmc_pkg::MOTION_W-1] ? tmc_pkg::MOTION_W'(-v) : v;
    endfunction

    // divide by two toward zero, leaving -1, 0 and 1 alone
    function automatic logic signed [tmc_pkg::MOTION_W-1:0] f_halve(
        input logic signed [tmc_pkg::MOTION_W-1:0] v
    );
        logic signed [tmc_pkg::MOTION_W-1:0] t;
        t = v + $signed({{(tmc_pkg::MOTION_W-1){1'b0}}, v[tmc_pkg::MOTION_W-1]});
        return (v > 8'sd1 || v < -8'sd1) ? (t >>> 1) : v;
    endfunction

    // small-move detection and deceleration
    always_comb begin
        w_absx0   = f_abs(i_x);
        w_absy0   = f_abs(i_y);
        w_mag0    = MAG_W'(w_absx0) + MAG_W'(w_absy0);
        w_nonzero = (i_x != '0) || (i_y != '0);
        w_small   = w_mag0 <= MAG_W'(i_cfg.small_thr);
        w_elapsed = i_now[tmc_pkg::HOLD_W-1:0] - r_small_start;
        w_slow    = w_nonzero && w_small && r_small_mode && (w_elapsed > i_cfg.decel_hold);
        w_x1      = w_slow ? f_halve(i_x) : i_x;
        w_y1      = w_slow ? f_halve(i_y) : i_y;

        n_small_mode  = r_small_mode;
        n_small_start = r_small_start;
        if (w_nonzero) begin
            n_small_mode = w_small;
            if (w_small && !r_small_mode) begin
                n_small_start = i_now[tmc_pkg::HOLD_W-1:0];
            end
        end
    end

    // jitter filter and streak counting
    always_comb begin
        w_absx1  = f_abs(w_x1);
        w_absy1  = f_abs(w_y1);
        w_mag1   = MAG_W'(w_absx1) + MAG_W'(w_absy1);
        w_active = i_jit_on && !i_layer;
        w_is2    = w_mag1 == MAG_W'(2);
        w_dgap   = i_now - r_last_double;
        w_sgap   = i_now - r_last_single;
        w_treat1 = w_active && w_is2 && (w_dgap > tmc_pkg::TIME_W'(i_cfg.double_gap));
        w_small1 = (w_mag1 == MAG_W'(1)) || w_treat1;
        w_magj   = w_treat1 ? MAG_W'(1) : w_mag1;

        if (w_sgap < tmc_pkg::TIME_W'(i_cfg.streak_gap)) begin
            n_streak = (r_streak == tmc_pkg::STREAK_MAX) ? r_streak : r_streak + 8'd1;
        end else begin
            n_streak = '0;
        end
        w_streak_eff = (w_active && w_small1) ? n_streak : r_streak;
        w_zero       = w_active && w_small1 && (n_streak < i_cfg.streak_thr);

        o_x   = w_zero ? '0 : w_x1;
        o_y   = w_zero ? '0 : w_y1;
        o_sig = ((w_magj != '0) && (i_layer || !i_jit_on)) || (w_magj > MAG_W'(1)) ||
                (w_small1 && (w_streak_eff > i_cfg.streak_thr));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_small_mode  <= 1'b0;
            r_small_start <= '0;
            r_last_double <= '0;
            r_last_single <= '0;
            r_streak      <= '0;
        end else if (i_en) begin
            r_small_mode  <= n_small_mode;
            r_small_start <= n_small_start;
            if (w_active && w_is2) begin
                r_last_double <= i_now;
            end
            if (w_active && w_small1) begin
                r_last_single <= i_now;
                r_streak      <= n_streak;
            end
        end
    end

endmodule

@@ rtl/trackball_motion_conditioner.sv @@
// trackball_motion_conditioner: top level, stream ports, input and result registers
// depends on tmc_pkg, tmc_cfg_regs, tmc_scroll_axis, tmc_motion_core
//
//  channel  | direction | handshake          | content
//  s_axis   | in        | tvalid/tready      | one motion report per beat
//  m_axis   | out       | tvalid/tready      | one conditioned report per beat
//  cfg      | in        | i_cfg_we           | register index and write data
//
// one beat in, one beat out; a taken beat goes to the input register, then to the
// result register, which sets output valid; a stalled output can hold it in between
// sustained throughput is one report per cycle while the output is not stalled: all work
// sits between the input register and the result register, state updates in the same cycle
// reset is synchronous, active low; clears state, valid flags and configuration
// a stalled output holds the result; with the input register also full the input
// is held off, tready following i_m_axis_tready in the same cycle

module trackball_motion_conditioner #(
    parameter int WHEEL_DIV = tmc_pkg::WHEEL_DIV_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // dx, dy, wheel_v, wheel_h, now_ms (from bit 0)
    input  logic [tmc_pkg::S_TDATA_W-1:0]       i_s_axis_tdata,
    // drag_mode, jitter_filter_on, mouse_layer_active (from bit 0)
    input  logic [tmc_pkg::S_TUSER_W-1:0]       i_s_axis_tuser,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // out_x, out_y, out_h, out_v (from bit 0)
    output logic [tmc_pkg::M_TDATA_W-1:0]       o_m_axis_tdata,
    // significant_move
    output logic [tmc_pkg::M_TUSER_W-1:0]       o_m_axis_tuser,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    input  logic                                i_cfg_we,
    input  logic [tmc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [tmc_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    tmc_pkg::t_cfg w_cfg;

    // input register
    logic                                r_in_valid;
    logic signed [tmc_pkg::MOTION_W-1:0] r_in_dx, r_in_dy, r_in_wv, r_in_wh;
    logic [tmc_pkg::TIME_W-1:0]          r_in_now;
    logic                                r_in_drag, r_in_jit, r_in_layer;

    // result register
    logic                                r_out_valid;
    logic [tmc_pkg::M_TDATA_W-1:0]       r_out_data;
    logic                                r_out_sig;

    logic                                w_s_take, w_adv;
    logic signed [tmc_pkg::MOTION_W-1:0] w_whx, w_why;
    logic signed [tmc_pkg::MOTION_W-1:0] w_x, w_y, w_h, w_v, w_cx, w_cy;
    logic                                w_sig;

    // handshake: input register moves on whenever the result register frees up
    assign w_adv           = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_adv;
    assign w_s_take        = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= w_s_take || (r_in_valid && !w_adv);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_take) begin
            r_in_dx    <= i_s_axis_tdata[7:0];
            r_in_dy    <= i_s_axis_tdata[15:8];
            r_in_wv    <= i_s_axis_tdata[23:16];
            r_in_wh    <= i_s_axis_tdata[31:24];
            r_in_now   <= i_s_axis_tdata[63:32];
            r_in_drag  <= i_s_axis_tuser[0];
            r_in_jit   <= i_s_axis_tuser[1];
            r_in_layer <= i_s_axis_tuser[2];
        end
    end

    tmc_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    // drag-scroll axes
    tmc_scroll_axis #(.WHEEL_DIV(WHEEL_DIV)) u_scroll_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv && r_in_drag),
        .i_d     (r_in_dx),
        .o_wheel (w_whx)
    );

    tmc_scroll_axis #(.WHEEL_DIV(WHEEL_DIV)) u_scroll_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv && r_in_drag),
        .i_d     (r_in_dy),
        .o_wheel (w_why)
    );

    // drag mode zeroes cursor motion and replaces the wheel counts
    assign w_x = r_in_drag ? '0 : r_in_dx;
    assign w_y = r_in_drag ? '0 : r_in_dy;
    assign w_h = r_in_drag ? w_whx : r_in_wh;
    assign w_v = r_in_drag ? w_why : r_in_wv;

    tmc_motion_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_adv),
        .i_cfg    (w_cfg),
        .i_x      (w_x),
        .i_y      (w_y),
        .i_now    (r_in_now),
        .i_jit_on (r_in_jit),
        .i_layer  (r_in_layer),
        .o_x      (w_cx),
        .o_y      (w_cy),
        .o_sig    (w_sig)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_data <= {w_v, w_h, w_cy, w_cx};
            r_out_sig  <= w_sig;
        end
    end

    assign o_m_axis_tvalid   = r_out_valid;
    assign o_m_axis_tdata    = r_out_data;
    assign o_m_axis_tuser[0] = r_out_sig;

`ifndef ASSERT_OFF
    // drag mode never moves the cursor and never wakes the layer
    a_drag_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in_drag) |=> (o_m_axis_tdata[15:0] == '0 && !o_m_axis_tuser[0]))
        else $error("drag-mode beat carried cursor motion or wake flag");

    // outside drag mode the wheel counts pass straight through
    a_wheel_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && !r_in_drag) |=>
            (o_m_axis_tdata[31:16] == $past({r_in_wv, r_in_wh})))
        else $error("wheel counts altered outside drag mode");

    // input back-pressure only while the result register is held
    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (r_out_valid && !i_m_axis_tready && r_in_valid))
        else $error("input stalled without a held result");

    // every advanced beat lands in the result register
    a_adv_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> o_m_axis_tvalid)
        else $error("advanced beat lost before the output");
`endif

endmodule

@@ sim/trackball_motion_conditioner_tb.sv @@
// trackball_motion_conditioner_tb: self-checking bench for the motion conditioner
// depends on tmc_pkg and trackball_motion_conditioner; models the block in-line and
// compares every output beat against the predicted report
`timescale 1ns / 100ps

module trackball_motion_conditioner_tb;

    localparam int SCROLL_DIV  = 8;
    localparam int CYCLE_LIMIT = 200000;
    // an index past the last register, writes to it must change nothing
    localparam logic [tmc_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;

    // one motion report and one conditioned report
    typedef struct packed {
        logic signed [7:0] dx;
        logic signed [7:0] dy;
        logic signed [7:0] wv;
        logic signed [7:0] wh;
        logic [31:0]       now;
        logic              drag;
        logic              jit;
        logic              layer;
    } t_motion_report;

    typedef struct packed {
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] h;
        logic [7:0] v;
        logic       sig;
    } t_cond_report;

    // flavors of random runs
    typedef enum int {
        RUN_STREAK,
        RUN_SINGLES,
        RUN_SMALL,
        RUN_DRAG,
        RUN_NOISE,
        RUN_BROKEN
    } t_run_kind;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic [tmc_pkg::S_TDATA_W-1:0]  s_data = '0;
    logic [tmc_pkg::S_TUSER_W-1:0]  s_user = '0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    logic [tmc_pkg::M_TDATA_W-1:0]  m_data;
    logic [tmc_pkg::M_TUSER_W-1:0]  m_user;
    logic                           m_valid;
    logic                           m_ready = 1'b1;
    logic                           cfg_we = 1'b0;
    logic [tmc_pkg::CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [tmc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // predictor copy of configuration and state
    logic [7:0]        cfg_small_thr;
    logic [15:0]       cfg_decel_hold;
    logic [15:0]       cfg_double_gap;
    logic [15:0]       cfg_streak_gap;
    logic [7:0]        cfg_streak_thr;
    logic signed [15:0] rem_x;
    logic signed [15:0] rem_y;
    logic              in_small_mode;
    logic [15:0]       small_t0;
    logic [31:0]       t_last_double;
    logic [31:0]       t_last_single;
    logic [7:0]        streak_len;

    t_cond_report expected_reports[$];
    t_cond_report oldest_expected;
    logic [31:0]  t_ms;
    bit           idle_on = 1'b0;
    int           stall_left = 0;
    int           fail_count = 0;
    int           items_sent = 0;
    int           results_seen = 0;
    int           phases_run = 0;
    int           cycle_count = 0;

    trackball_motion_conditioner #(
        .WHEEL_DIV(SCROLL_DIV)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run guard
    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t ns: timeout with %0d reports outstanding", $time,
                     expected_reports.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic int l1_mag(int a, int b);
        return (a < 0 ? -a : a) + (b < 0 ? -b : b);
    endfunction

    function automatic int halve_step(int a);
        return ((a < 0 ? -a : a) > 1) ? a / 2 : a;
    endfunction

    function automatic logic [7:0] neg_sat8(int q);
        int n;
        n = -q;
        if (n > 127) n = 127;
        if (n < -128) n = -128;
        return 8'(n);
    endfunction

    // conditions one report and advances the predictor state
    function automatic t_cond_report predict_motion(t_motion_report r);
        int x, y, h, v, mag, acc, qh, qv;
        logic [15:0] now16;
        logic [15:0] held;
        logic [31:0] gap;
        bit one_unit;
        t_cond_report res;
        x = int'($signed(r.dx));
        y = int'($signed(r.dy));
        v = int'($signed(r.wv));
        h = int'($signed(r.wh));
        res.h = 8'(h);
        res.v = 8'(v);

        // drag scroll: accumulate, divide toward zero, invert
        if (r.drag) begin
            acc = int'(rem_x) + x;
            qh = acc / SCROLL_DIV;
            rem_x = 16'(acc - qh * SCROLL_DIV);
            acc = int'(rem_y) + y;
            qv = acc / SCROLL_DIV;
            rem_y = 16'(acc - qv * SCROLL_DIV);
            res.h = neg_sat8(qh);
            res.v = neg_sat8(qv);
            x = 0;
            y = 0;
        end

        // slow-motion deceleration
        if (x != 0 || y != 0) begin
            mag = l1_mag(x, y);
            if (mag <= int'(cfg_small_thr)) begin
                now16 = r.now[15:0];
                if (!in_small_mode) begin
                    in_small_mode = 1'b1;
                    small_t0 = now16;
                end
                held = now16 - small_t0;
                if (held > cfg_decel_hold) begin
                    x = halve_step(x);
                    y = halve_step(y);
                end
            end else begin
                in_small_mode = 1'b0;
            end
        end

        mag = l1_mag(x, y);
        one_unit = (mag == 1);

        // jitter filter
        if (r.jit && !r.layer) begin
            if (mag == 2) begin
                gap = r.now - t_last_double;
                if (gap > {16'd0, cfg_double_gap}) begin
                    mag = 1;
                    one_unit = 1'b1;
                end
                t_last_double = r.now;
            end
            if (one_unit) begin
                gap = r.now - t_last_single;
                if (gap < {16'd0, cfg_streak_gap}) begin
                    if (streak_len != tmc_pkg::STREAK_MAX) streak_len = streak_len + 8'd1;
                end else begin
                    streak_len = 8'd0;
                end
                t_last_single = r.now;
                if (streak_len < cfg_streak_thr) begin
                    x = 0;
                    y = 0;
                end
            end
        end

        res.sig = (r.layer && mag > 0) || (!r.jit && mag > 0) || (mag > 1) ||
                  (one_unit && streak_len > cfg_streak_thr);
        res.x = 8'(x);
        res.y = 8'(y);
        return res;
    endfunction

    function automatic t_motion_report report_of(
        input logic signed [7:0] dx, input logic signed [7:0] dy,
        input logic signed [7:0] wv, input logic signed [7:0] wh,
        input logic [31:0] now, input bit drag, input bit jit, input bit layer);
        t_motion_report r;
        r.dx = dx;
        r.dy = dy;
        r.wv = wv;
        r.wh = wh;
        r.now = now;
        r.drag = drag;
        r.jit = jit;
        r.layer = layer;
        return r;
    endfunction

    // random report of one run flavor, advances the time base
    function automatic t_motion_report make_item(t_run_kind kind);
        t_motion_report r;
        int lim, ax, ay, pick;
        r = report_of(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 32'd0,
                      1'b0, 1'($urandom), $urandom_range(0, 3) == 0);
        case (kind)
            RUN_STREAK, RUN_SINGLES, RUN_BROKEN: begin
                if (kind == RUN_BROKEN) t_ms = t_ms + $urandom_range(0, 60);
                else t_ms = t_ms + $urandom_range(0, 12);
                pick = $urandom_range(0, 5);
                ax = (pick == 0 || pick == 2 || pick == 4) ? 1 : 0;
                ay = (pick == 1 || pick == 3 || pick == 4) ? 1 : 0;
                if (kind == RUN_SINGLES && pick == 4) ay = 0;
                if (pick == 5) begin
                    ax = 1;
                    ay = (kind == RUN_SINGLES) ? 0 : 1;
                end
                r.dx = $urandom_range(0, 1) ? 8'(ax) : -8'(ax);
                r.dy = $urandom_range(0, 1) ? 8'(ay) : -8'(ay);
                r.jit = 1'b1;
                if (kind == RUN_BROKEN) begin
                    r.layer = 1'($urandom);
                    r.drag = $urandom_range(0, 5) == 0;
                end else begin
                    r.layer = (kind == RUN_STREAK) && ($urandom_range(0, 15) == 0);
                end
            end
            RUN_SMALL: begin
                t_ms = t_ms + $urandom_range(0, 30);
                lim = (cfg_small_thr > 8'd127) ? 127 : int'(cfg_small_thr);
                if ($urandom_range(0, 7) == 0) lim = lim + 1;
                if (lim > 127) lim = 127;
                ax = $urandom_range(0, lim);
                ay = $urandom_range(0, lim - ax);
                r.dx = $urandom_range(0, 1) ? 8'(ax) : -8'(ax);
                r.dy = $urandom_range(0, 1) ? 8'(ay) : -8'(ay);
            end
            RUN_DRAG: begin
                t_ms = t_ms + $urandom_range(0, 20);
                r.drag = 1'b1;
            end
            default: begin
                if ($urandom_range(0, 7) == 0) t_ms = t_ms + $urandom;
                else t_ms = t_ms + $urandom_range(0, 100);
                r.drag = 1'($urandom);
                r.layer = 1'($urandom);
            end
        endcase
        r.now = t_ms;
        return r;
    endfunction

    // offers one report beat and records its prediction on accept
    task automatic send_report(input t_motion_report r);
        int gap;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= {r.now, r.wh, r.wv, r.dy, r.dx};
        s_user  <= {r.layer, r.jit, r.drag};
        do @(posedge i_clk); while (!s_ready);
        expected_reports.push_back(predict_motion(r));
        items_sent = items_sent + 1;
    endtask

    // stop sending and let every outstanding report drain
    task automatic settle();
        s_valid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [tmc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] val);
        case (idx)
            tmc_pkg::CFG_SMALL_THR:  cfg_small_thr  = val[7:0];
            tmc_pkg::CFG_DECEL_HOLD: cfg_decel_hold = val;
            tmc_pkg::CFG_DOUBLE_GAP: cfg_double_gap = val;
            tmc_pkg::CFG_STREAK_GAP: cfg_streak_gap = val;
            tmc_pkg::CFG_STREAK_THR: cfg_streak_thr = val[7:0];
            default: ;
        endcase
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_all(input logic [7:0] thr, input logic [15:0] hold,
                             input logic [15:0] dgap, input logic [15:0] sgap,
                             input logic [7:0] sthr);
        write_reg(tmc_pkg::CFG_SMALL_THR, {8'd0, thr});
        write_reg(tmc_pkg::CFG_DECEL_HOLD, hold);
        write_reg(tmc_pkg::CFG_DOUBLE_GAP, dgap);
        write_reg(tmc_pkg::CFG_STREAK_GAP, sgap);
        write_reg(tmc_pkg::CFG_STREAK_THR, {8'd0, sthr});
    endtask

    // field extremes, drag scrolling, pass-through and basic jitter cases
    task automatic test_directed_extremes();
        idle_on = 1'b1;
        t_ms = 32'd1000;
        send_report(report_of(0, 0, 0, 0, t_ms, 0, 0, 0));
        t_ms = t_ms + 3;
        send_report(report_of(127, -128, -128, 127, t_ms, 0, 0, 0));
        // full magnitude of 256 must not wrap
        send_report(report_of(-128, -128, 5, -5, t_ms, 0, 0, 0));
        t_ms = t_ms + 1;
        send_report(report_of(1, 0, 0, 0, t_ms, 0, 0, 0));
        // held past the default hold time, gets halved
        t_ms = t_ms + 250;
        send_report(report_of(2, 0, 0, 0, t_ms, 0, 0, 0));
        // drag scrolling with remainders carrying over
        send_report(report_of(-128, 127, 55, -9, t_ms, 1, 0, 0));
        send_report(report_of(7, -7, -128, 127, t_ms, 1, 0, 0));
        send_report(report_of(1, 0, 0, 0, t_ms, 1, 0, 0));
        send_report(report_of(-1, -1, 0, 0, t_ms, 1, 0, 0));
        send_report(report_of(0, 0, -128, 127, t_ms, 0, 0, 0));
        // jitter filter
        t_ms = t_ms + 40;
        send_report(report_of(1, 0, 3, 3, t_ms, 0, 1, 0));
        t_ms = t_ms + 1;
        send_report(report_of(1, 1, 0, 0, t_ms, 0, 1, 0));
        t_ms = t_ms + 2;
        send_report(report_of(-1, 1, 0, 0, t_ms, 0, 1, 0));
        send_report(report_of(0, -1, 0, 0, t_ms, 0, 1, 1));
        // time wrap at 32 bits
        send_report(report_of(0, 1, 0, 0, 32'hFFFF_FFFF, 0, 1, 0));
        send_report(report_of(-1, 0, 0, 0, 32'h0000_0000, 0, 1, 0));
        send_report(report_of(3, 3, 127, -128, 32'h0000_0001, 1, 1, 0));
        settle();
    endtask

    // streak building, unused index write, double-move gap
    task automatic test_jitter_streak();
        int k;
        write_all(tmc_pkg::SMALL_THR_RST, tmc_pkg::DECEL_HOLD_RST, tmc_pkg::DOUBLE_GAP_RST,
                  tmc_pkg::STREAK_GAP_RST, 8'd3);
        write_reg(CFG_IDX_UNUSED, 16'hFFFF);
        idle_on = 1'b0;
        t_ms = 32'h8000_0000;
        for (k = 0; k < 8; k++) begin
            t_ms = t_ms + 2;
            send_report(report_of($urandom_range(0, 1) ? 1 : -1, 0, 0, 0, t_ms, 0, 1, 0));
        end
        // a long gap breaks the streak
        t_ms = t_ms + 20;
        send_report(report_of(0, 1, 0, 0, t_ms, 0, 1, 0));
        t_ms = t_ms + 30;
        send_report(report_of(1, -1, 0, 0, t_ms, 0, 1, 0));
        t_ms = t_ms + 25;
        send_report(report_of(-1, -1, 0, 0, t_ms, 0, 1, 0));
        t_ms = t_ms + 26;
        send_report(report_of(1, 1, 0, 0, t_ms, 0, 1, 0));
        settle();
    endtask

    // deceleration across the 16-bit time wrap, hold of zero, break-out by a big move
    task automatic test_small_decel();
        int k;
        write_reg(tmc_pkg::CFG_SMALL_THR, 16'd4);
        write_reg(tmc_pkg::CFG_DECEL_HOLD, 16'd20);
        idle_on = 1'b1;
        t_ms = 32'h1234_FFF0;
        for (k = 0; k < 8; k++) begin
            t_ms = t_ms + 5;
            send_report(report_of((k % 2) ? 2 : -3, (k % 3) ? 1 : -2, 0, 0, t_ms, 0, 0, 0));
        end
        send_report(report_of(50, 0, 0, 0, t_ms, 0, 0, 0));
        t_ms = t_ms + 5;
        send_report(report_of(4, 0, 0, 0, t_ms, 0, 0, 0));
        // drain before touching a register
        settle();
        write_reg(tmc_pkg::CFG_DECEL_HOLD, 16'd0);
        t_ms = t_ms + 1;
        send_report(report_of(-4, 0, 0, 0, t_ms, 0, 0, 0));
        send_report(report_of(1, -1, 0, 0, t_ms, 0, 0, 0));
        settle();
    endtask

    // one register setting, then random runs of mixed flavors
    task automatic run_phase(input logic [7:0] thr, input logic [15:0] hold,
                             input logic [15:0] dgap, input logic [15:0] sgap,
                             input logic [7:0] sthr, input int n_items, input bit singles);
        int done, run_len, k, pick;
        t_run_kind kind;
        write_all(thr, hold, dgap, sgap, sthr);
        t_ms = $urandom;
        done = 0;
        while (done < n_items) begin
            pick = $urandom_range(0, 99);
            if (singles)        kind = RUN_SINGLES;
            else if (pick < 35) kind = RUN_STREAK;
            else if (pick < 60) kind = RUN_SMALL;
            else if (pick < 75) kind = RUN_DRAG;
            else if (pick < 90) kind = RUN_NOISE;
            else                kind = RUN_BROKEN;
            run_len = (kind == RUN_STREAK || kind == RUN_SINGLES) ?
                      $urandom_range(1, 70) : $urandom_range(1, 15);
            idle_on = $urandom_range(0, 3) != 0;
            for (k = 0; k < run_len && done < n_items; k++) begin
                send_report(make_item(kind));
                done = done + 1;
            end
        end
        settle();
        phases_run = phases_run + 1;
    endtask

    task automatic test_random_phases();
        run_phase(tmc_pkg::SMALL_THR_RST, tmc_pkg::DECEL_HOLD_RST, tmc_pkg::DOUBLE_GAP_RST,
                  tmc_pkg::STREAK_GAP_RST, tmc_pkg::STREAK_THR_RST, 30, 1'b0);
        run_phase(8'd0, 16'd0, 16'd0, 16'd0, 8'd0, 20, 1'b0);
        run_phase(8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd255, 20, 1'b0);
        run_phase(8'd8, 16'd30, 16'd5, 16'd12, 8'd4, 30, 1'b0);
        run_phase(8'($urandom_range(0, 10)), 16'($urandom_range(0, 100)),
                  16'($urandom_range(0, 40)), 16'($urandom_range(0, 15)),
                  8'($urandom_range(0, 20)), 30, 1'b0);
        run_phase(8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  8'($urandom), 20, 1'b0);
        // long unbroken streak to drive the counter into saturation
        run_phase(8'd3, 16'd100, 16'd25, 16'hFFFF, 8'd250, 260, 1'b1);
    endtask

    // result side: random back-pressure after each beat while idle_on is set
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            if (stall_left == 0) m_ready <= 1'b1;
        end else if (i_rst_n && m_valid && m_ready && idle_on) begin
            stall_left = $urandom_range(0, 3);
            if (stall_left != 0) m_ready <= 1'b0;
        end
    end

    task automatic check_field(input string what, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) begin
            fail_count = fail_count + 1;
            if (fail_count <= 40)
                $display("%0t ns: %s mismatch, expected %h actual %h", $time, what,
                         want, got);
        end
    endtask

    // compare each output beat with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && m_valid && m_ready) begin
            results_seen = results_seen + 1;
            if (expected_reports.size() == 0) begin
                fail_count = fail_count + 1;
                if (fail_count <= 40)
                    $display("%0t ns: unexpected beat, expected none actual %h/%h",
                             $time, m_data, m_user);
            end else begin
                oldest_expected = expected_reports.pop_front();
                check_field("out_x", oldest_expected.x, m_data[7:0]);
                check_field("out_y", oldest_expected.y, m_data[15:8]);
                check_field("out_h", oldest_expected.h, m_data[23:16]);
                check_field("out_v", oldest_expected.v, m_data[31:24]);
                check_field("significant_move", {7'd0, oldest_expected.sig},
                            {7'd0, m_user[0]});
            end
        end
    end

    initial begin
        // predictor matches the block's reset state
        cfg_small_thr  = tmc_pkg::SMALL_THR_RST;
        cfg_decel_hold = tmc_pkg::DECEL_HOLD_RST;
        cfg_double_gap = tmc_pkg::DOUBLE_GAP_RST;
        cfg_streak_gap = tmc_pkg::STREAK_GAP_RST;
        cfg_streak_thr = tmc_pkg::STREAK_THR_RST;
        rem_x = '0;
        rem_y = '0;
        in_small_mode = 1'b0;
        small_t0 = '0;
        t_last_double = '0;
        t_last_single = '0;
        streak_len = '0;
        t_ms = '0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_extremes();
        test_jitter_streak();
        test_small_decel();
        test_random_phases();

        $display("covered %0d motion reports, %0d output beats, %0d random register settings",
                 items_sent, results_seen, phases_run);
        $display("drag scroll, deceleration, jitter streaks and wheel pass-through exercised");
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/tmc_pkg.sv
rtl/tmc_cfg_regs.sv
rtl/tmc_scroll_axis.sv
rtl/tmc_motion_core.sv
rtl/trackball_motion_conditioner.sv
sim/trackball_motion_conditioner_tb.sv
